[sv/hrlp_pkg.sv]
// Package for the HTTP request line parser.
// Holds the method table, result codes and the record passed from front to back.
// Used by every module of the block; depends on nothing.
package hrlp_pkg;

	localparam int MAX_URL_LENGTH = 1024;
	localparam int URL_CNT_W      = $clog2(MAX_URL_LENGTH + 1);
	localparam int URL_LEN_W      = 11;
	localparam int TOKEN_BYTES    = 7;
	localparam int NUM_METHODS    = 9;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] SPACE_BYTE = 8'h20;

	localparam logic [3:0] METHOD_UNDEF = 4'd9;

	localparam logic [1:0] ST_URL_CLOSED = 2'd0;
	localparam logic [1:0] ST_MSG_ENDED  = 2'd1;
	localparam logic [1:0] ST_NO_SEP     = 2'd2;
	localparam logic [1:0] ST_TRUNCATED  = 2'd3;

	localparam logic KIND_URL     = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Method names packed with the first character in the low byte.
	localparam logic [55:0] METHOD_CHARS [NUM_METHODS] = '{
		56'h00000000544547,
		56'h00000044414548,
		56'h00000054534F50,
		56'h00000000545550,
		56'h004554454C4544,
		56'h5443454E4E4F43,
		56'h534E4F4954504F,
		56'h00004543415254,
		56'h00004843544150
	};

	localparam logic [3:0] METHOD_LEN [NUM_METHODS] = '{
		4'd3, 4'd4, 4'd4, 4'd3, 4'd6, 4'd7, 4'd7, 4'd5, 4'd5
	};

	typedef struct packed {
		logic                 has_url;
		logic                 has_sum;
		logic [7:0]           url_byte;
		logic [3:0]           method;
		logic [URL_LEN_W-1:0] length;
		logic [1:0]           status;
	} hrlp_rec_t;

	function automatic logic [3:0] match_method(input logic [55:0] chars,
			input logic [3:0] count);
		logic [3:0] code;
		code = METHOD_UNDEF;
		if (count != 4'd0 && count <= 4'(TOKEN_BYTES)) begin
			for (int m = NUM_METHODS - 1; m >= 0; m--) begin
				if (METHOD_LEN[m] == count && METHOD_CHARS[m] == chars) begin
					code = 4'(m);
				end
			end
		end
		return code;
	endfunction

endpackage

[sv/hrlp_front.sv]
// Front part of the HTTP request line parser: takes one byte per accepted item,
// tracks the request line phase and builds a result record for the queue.
// Depends on hrlp_pkg.
module hrlp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        data_byte,
	input  logic              end_of_message,
	output logic              rec_push,
	output hrlp_pkg::hrlp_rec_t rec
);
	import hrlp_pkg::*;

	localparam logic [1:0] PH_METHOD = 2'd0;
	localparam logic [1:0] PH_SKIP   = 2'd1;
	localparam logic [1:0] PH_URL    = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	logic [1:0]           phase_q, phase_d;
	logic [55:0]          chars_q, chars_d;
	logic [3:0]           tcount_q, tcount_d;
	logic [3:0]           method_q, method_d;
	logic [URL_CNT_W-1:0] ucount_q, ucount_d;
	logic                 trunc_q, trunc_d;
	logic                 is_space;

	assign is_space = (data_byte == SPACE_BYTE);

	always_comb begin
		phase_d  = phase_q;
		chars_d  = chars_q;
		tcount_d = tcount_q;
		method_d = method_q;
		ucount_d = ucount_q;
		trunc_d  = trunc_q;
		rec      = '0;
		unique case (phase_q)
			PH_METHOD: begin
				if (is_space) begin
					method_d = match_method(chars_q, tcount_q);
					phase_d  = PH_SKIP;
				end else begin
					for (int k = 0; k < TOKEN_BYTES; k++) begin
						if (tcount_q == 4'(k)) begin
							chars_d[8*k +: 8] = data_byte;
						end
					end
					if (tcount_q < 4'd8) begin
						tcount_d = tcount_q + 4'd1;
					end
				end
			end
			PH_SKIP: begin
				if (!is_space) begin
					phase_d = PH_URL;
				end
			end
			PH_URL: begin
				if (is_space) begin
					rec.has_sum = 1'b1;
					rec.status  = trunc_q ? ST_TRUNCATED : ST_URL_CLOSED;
					phase_d     = PH_DONE;
				end else if (ucount_q < URL_CNT_W'(MAX_URL_LENGTH)) begin
					ucount_d    = ucount_q + URL_CNT_W'(1);
					rec.has_url = 1'b1;
					rec.url_byte = data_byte;
				end else begin
					trunc_d = 1'b1;
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase
		rec.method = method_d;
		rec.length = URL_LEN_W'(ucount_d);
		if (end_of_message && phase_d != PH_DONE) begin
			rec.has_sum = 1'b1;
			if (phase_d == PH_METHOD) begin
				rec.method = METHOD_UNDEF;
				rec.length = '0;
				rec.status = ST_NO_SEP;
			end else begin
				rec.status = ST_MSG_ENDED;
			end
		end
	end

	assign rec_push = take && (rec.has_url || rec.has_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_METHOD;
			chars_q  <= '0;
			tcount_q <= '0;
			method_q <= METHOD_UNDEF;
			ucount_q <= '0;
			trunc_q  <= 1'b0;
		end else if (take) begin
			if (end_of_message) begin
				phase_q  <= PH_METHOD;
				chars_q  <= '0;
				tcount_q <= '0;
				method_q <= METHOD_UNDEF;
				ucount_q <= '0;
				trunc_q  <= 1'b0;
			end else begin
				phase_q  <= phase_d;
				chars_q  <= chars_d;
				tcount_q <= tcount_d;
				method_q <= method_d;
				ucount_q <= ucount_d;
				trunc_q  <= trunc_d;
			end
		end
	end

endmodule

[sv/hrlp_queue.sv]
// Short queue of result records between the front and back parts.
// Depends on hrlp_pkg.
module hrlp_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  hrlp_pkg::hrlp_rec_t             push_rec,
	input  logic                            pop,
	output logic                            not_empty,
	output logic                            full,
	output logic [hrlp_pkg::QUEUE_CNT_W-1:0] fill,
	output hrlp_pkg::hrlp_rec_t             head_rec
);
	import hrlp_pkg::*;

	hrlp_rec_t              mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] cnt_q;
	logic                   do_push;
	logic                   do_pop;

	assign not_empty = (cnt_q != '0);
	assign full      = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign fill      = cnt_q;
	assign head_rec  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QUEUE_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QUEUE_CNT_W'(1);
			end
		end
	end

endmodule

[sv/hrlp_back.sv]
// Back part of the HTTP request line parser: takes records from the queue and
// delivers their URL byte and summary results one item at a time.
// Depends on hrlp_pkg.
module hrlp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rec_avail,
	input  hrlp_pkg::hrlp_rec_t rec,
	output logic                rec_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                out_kind,
	output logic [7:0]          out_byte,
	output logic [3:0]          out_method,
	output logic [hrlp_pkg::URL_LEN_W-1:0] out_length,
	output logic [1:0]          out_status,
	output logic                out_last
);
	import hrlp_pkg::*;

	hrlp_rec_t cur_q;
	logic      pend_url_q;
	logic      pend_sum_q;
	logic      handshake;
	logic      load;

	assign out_valid = pend_url_q || pend_sum_q;
	assign handshake = out_valid && out_ready;
	assign load      = !out_valid || (handshake && !(pend_url_q && pend_sum_q));
	assign rec_pop   = load && rec_avail;

	assign out_kind   = pend_url_q ? KIND_URL : KIND_SUMMARY;
	assign out_byte   = pend_url_q ? cur_q.url_byte : 8'd0;
	assign out_method = cur_q.method;
	assign out_length = cur_q.length;
	assign out_status = pend_url_q ? ST_URL_CLOSED : cur_q.status;
	assign out_last   = !pend_url_q;

	always_ff @(posedge clk) begin
		if (rec_pop) begin
			cur_q <= rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_url_q <= 1'b0;
			pend_sum_q <= 1'b0;
		end else if (load) begin
			pend_url_q <= rec_avail && rec.has_url;
			pend_sum_q <= rec_avail && rec.has_sum;
		end else if (handshake) begin
			pend_url_q <= 1'b0;
		end
	end

endmodule

[sv/http_request_line_parser.sv]
// Top level of the HTTP request line parser: front, record queue and back.
// Depends on hrlp_pkg, hrlp_front, hrlp_queue and hrlp_back.
//
// Channel  | Direction | Contents
// s_*      | in        | tdata[7:0] data_byte, tlast end_of_message
// m_*      | out       | tdata url_byte, method_code, url_length, status; tuser kind;
//          |           | tlast is_last
//
// One byte is taken per clock while the four-record queue has room.
// Each byte gives zero, one or two result items; of two, the URL byte item goes out first.
// The back part delivers one result item per clock when m_tready is high and the queue holds records.
// Reset returns the parser to the start of a message and empties the queue.
module http_request_line_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] url_byte, [11:8] method_code,
	                               // [22:12] url_length, [24:23] status
	output logic        m_tuser,   // [0] kind
	output logic        m_tlast
);
	import hrlp_pkg::*;

	logic                   take;
	logic                   rec_push;
	hrlp_rec_t              push_rec;
	logic                   rec_pop;
	logic                   q_not_empty;
	logic                   q_full;
	logic [QUEUE_CNT_W-1:0] q_fill;
	hrlp_rec_t              head_rec;
	logic [7:0]             out_byte;
	logic [3:0]             out_method;
	logic [URL_LEN_W-1:0]   out_length;
	logic [1:0]             out_status;

	assign s_tready = !q_full;
	assign take     = s_tvalid && s_tready;

	hrlp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.data_byte      (s_tdata),
		.end_of_message (s_tlast),
		.rec_push       (rec_push),
		.rec            (push_rec)
	);

	hrlp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rec_push),
		.push_rec  (push_rec),
		.pop       (rec_pop),
		.not_empty (q_not_empty),
		.full      (q_full),
		.fill      (q_fill),
		.head_rec  (head_rec)
	);

	hrlp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rec_avail  (q_not_empty),
		.rec        (head_rec),
		.rec_pop    (rec_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (m_tuser),
		.out_byte   (out_byte),
		.out_method (out_method),
		.out_length (out_length),
		.out_status (out_status),
		.out_last   (m_tlast)
	);

	assign m_tdata = {7'd0, out_status, out_length, out_method, out_byte};

	assert property (@(posedge clk) disable iff (!arst_n)
		q_fill <= QUEUE_CNT_W'(QUEUE_DEPTH))
		else $error("record queue holds more than its depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_SUMMARY && out_status == ST_NO_SEP)
		|-> (out_method == METHOD_UNDEF && out_length == '0))
		else $error("summary without separator carries a method or a length");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_URL)
		|-> (out_status == ST_URL_CLOSED && !m_tlast))
		else $error("URL byte item carries a status or ends the run");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rec_push && !rec_pop) |-> !q_full)
		else $error("record pushed into a full queue");

endmodule
